// ----- hdl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, operation codes and the structs passed along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 31;
  localparam int OUT_W   = 32;
  localparam int CAP_W   = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

  typedef enum logic [3:0] {
    OP_NONE  = 4'b0001,
    OP_HIT   = 4'b0010,
    OP_FILL  = 4'b0100,
    OP_EVICT = 4'b1000
  } op_t;

  typedef struct packed {
    logic              hit;
    logic              free;
    logic [VAL_W-1:0]  value;
    logic [RANK_W-1:0] rank;
  } chain_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             en;
    op_t              op;
    logic             write;
    logic [OCC_W-1:0] rank;
  } act_t;

endpackage

`default_nettype wire

// ----- hdl/lkvc_cell.sv -----
// ----------------------------------------------------------------------------
// LRU key/value cache entry cell
// Holds one entry, joins the lookup chain and applies the broadcast update.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lkvc_pkg::req_t   req,
  input  wire lkvc_pkg::act_t   act,
  input  wire lkvc_pkg::chain_t chain_in,
  output lkvc_pkg::chain_t      chain_out,
  output logic                  entry_valid
);

  logic                          valid;
  logic [lkvc_pkg::RANK_W-1:0]   rank;
  logic [lkvc_pkg::KEY_W-1:0]    key;
  logic [lkvc_pkg::VAL_W-1:0]    value;
  logic                          match;
  logic                          sel_hit;
  logic                          sel_free;
  logic                          target;
  logic                          age;

  always_comb begin
    match    = valid && (key == req.key);
    sel_hit  = match && !chain_in.hit;
    sel_free = !valid && !chain_in.free;

    chain_out.hit   = chain_in.hit | match;
    chain_out.free  = chain_in.free | !valid;
    chain_out.value = sel_hit ? value : chain_in.value;
    chain_out.rank  = sel_hit ? rank : chain_in.rank;

    case (act.op)
      lkvc_pkg::OP_HIT:   target = sel_hit;
      lkvc_pkg::OP_FILL:  target = sel_free;
      lkvc_pkg::OP_EVICT: target = valid && (lkvc_pkg::OCC_W'(rank) == act.rank);
      default:            target = 1'b0;
    endcase

    age = valid && !target && (lkvc_pkg::OCC_W'(rank) < act.rank);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (act.en) begin
      if (target) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (age) begin
        rank <= rank + lkvc_pkg::RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act.en && target && (act.op != lkvc_pkg::OP_HIT)) begin
      key <= req.key;
    end
    if (act.en && target && act.write) begin
      value <= req.value;
    end
  end

  assign entry_valid = valid;

endmodule

`default_nettype wire

// ----- hdl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The cache takes one request per clock while the output is not stalled and
// returns one result for each request; the request is registered on transfer,
// and the result is registered in turn when the request completes. The entry
// cells search all entries and apply the recency update on completion.
// A read hit returns the stored value, a read miss returns -1 and every write
// returns 0; found reports whether the key was present before the request.
// The capacity register at address 0 limits how many entries fill before
// the least recent one is replaced; zero acts as one and values above the
// entry count act as the entry count.
`default_nettype none

module lru_key_value_cache (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lkvc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lkvc_pkg::DATA_W-1:0]   pwdata,
  output logic      [lkvc_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0] key,
  input  wire logic [lkvc_pkg::VAL_W-1:0]    value,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               found,
  output logic signed [lkvc_pkg::OUT_W-1:0]  read_value
);

  logic [lkvc_pkg::CAP_W-1:0]   capacity;
  logic [lkvc_pkg::OCC_W-1:0]   occupancy;
  logic [lkvc_pkg::OCC_W-1:0]   eff_cap;
  logic                         busy;
  logic                         req_mode;
  lkvc_pkg::req_t               req;
  lkvc_pkg::act_t               act;
  lkvc_pkg::op_t                op;
  lkvc_pkg::chain_t             chain [lkvc_pkg::ENTRIES+1];
  logic [lkvc_pkg::ENTRIES-1:0] valid_vec;
  logic                         complete;
  logic                         accept;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[lkvc_pkg::ADDR_W-1:2] == lkvc_pkg::REG_CAPACITY);
  assign prdata    = (paddr[lkvc_pkg::ADDR_W-1:2] == lkvc_pkg::REG_CAPACITY)
                     ? lkvc_pkg::DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  assign complete = busy && (!out_valid || !out_stall);
  assign in_stall = busy && !complete;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (complete) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req.key   <= key;
      req.value <= value;
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < lkvc_pkg::ENTRIES; i++) begin : g_cell
    lkvc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .req         (req),
      .act         (act),
      .chain_in    (chain[i]),
      .chain_out   (chain[i+1]),
      .entry_valid (valid_vec[i])
    );
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = lkvc_pkg::OCC_W'(1);
    end else if (int'(capacity) > lkvc_pkg::ENTRIES) begin
      eff_cap = lkvc_pkg::OCC_W'(lkvc_pkg::ENTRIES);
    end else begin
      eff_cap = lkvc_pkg::OCC_W'(capacity);
    end

    if (chain[lkvc_pkg::ENTRIES].hit) begin
      op = lkvc_pkg::OP_HIT;
    end else if (!req_mode) begin
      op = lkvc_pkg::OP_NONE;
    end else if (occupancy < eff_cap) begin
      op = lkvc_pkg::OP_FILL;
    end else begin
      op = lkvc_pkg::OP_EVICT;
    end

    act.en    = complete;
    act.op    = op;
    act.write = req_mode;
    case (op)
      lkvc_pkg::OP_HIT:   act.rank = lkvc_pkg::OCC_W'(chain[lkvc_pkg::ENTRIES].rank);
      lkvc_pkg::OP_FILL:  act.rank = occupancy;
      lkvc_pkg::OP_EVICT: act.rank = occupancy - lkvc_pkg::OCC_W'(1);
      default:            act.rank = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (complete && (op == lkvc_pkg::OP_FILL)) begin
      occupancy <= occupancy + lkvc_pkg::OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (complete) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      found <= chain[lkvc_pkg::ENTRIES].hit;
      if (req_mode) begin
        read_value <= '0;
      end else if (chain[lkvc_pkg::ENTRIES].hit) begin
        read_value <= {1'b0, chain[lkvc_pkg::ENTRIES].value};
      end else begin
        read_value <= '1;
      end
    end
  end

  // The occupancy count always equals the number of valid entries.
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(occupancy))
    else $error("occupancy does not match valid entries");

  // A fill only happens when some entry is free.
  a_fill_free: assert property (@(posedge clk) disable iff (rst)
    complete && (op == lkvc_pkg::OP_FILL) |-> chain[lkvc_pkg::ENTRIES].free)
    else $error("fill without a free entry");

  // A fill grows the occupancy by one.
  a_fill_grow: assert property (@(posedge clk) disable iff (rst)
    complete && (op == lkvc_pkg::OP_FILL)
    |=> occupancy == $past(occupancy) + lkvc_pkg::OCC_W'(1))
    else $error("fill did not grow occupancy");

  // Every completed request offers its result on the next cycle.
  a_result_next: assert property (@(posedge clk) disable iff (rst)
    complete |=> out_valid)
    else $error("completed request without result");

endmodule

`default_nettype wire
